FILE: design/rrw_pkg.sv
// ----------------------------------------------------------------------------
// Receive reorder window package
// Beat types, field widths and status codes shared by the reorder window.
// ----------------------------------------------------------------------------
package rrw_pkg;

  localparam int unsigned SeqW     = 31;
  localparam int unsigned LenW     = 16;
  localparam int unsigned DoneW    = 32;
  localparam int unsigned SlotOutW = 6;
  localparam int unsigned MaxW     = 32;

  typedef enum logic [1:0] {
    StAccept = 2'd0,
    StDrain  = 2'd1,
    StGap    = 2'd2
  } status_e;

  typedef struct packed {
    logic [SeqW-1:0]         seq;
    logic [LenW-1:0]         pkt_len;
    logic                    exit_flag;
    logic signed [DoneW-1:0] delivered_seq;
  } pkt_in_t;

  typedef struct packed {
    status_e                status;
    logic [SlotOutW-1:0]    slot;
    logic                   store_payload;
    logic signed [MaxW-1:0] highest_seq;
  } result_t;

endpackage

FILE: design/receive_reorder_window_top.sv
// ----------------------------------------------------------------------------
// Receive reorder window
// Sliding-window reorder buffer for one stream: maps each arriving packet
// descriptor to a ring slot and reports store, drain or gap failure.
// ----------------------------------------------------------------------------
// Usage:
// A descriptor beat on the input channel carries the sequence number, length,
// exit flag and the consumer's delivered-up-to sequence. Each beat gives
// exactly one result beat with the status, the ring slot, whether the payload
// is to be written at that slot, and the highest stored sequence.
// The slot memory is read as the beat is taken into the evaluation stage, and
// the result register is loaded when that stage advances into it.
// Throughput is one beat per cycle unless the clearing pass or a receiver stall
// holds it; a write to a slot is forwarded to a read of the same slot by the following beat.
// After reset a clearing pass zeroes the slot memory, one slot per cycle, and
// in_stall_o stays high until it ends. SLOTS must be a power of two.
// When the receiver stalls, the result register holds its beat, the beat in
// the evaluation stage, if there is one, waits behind it and in_stall_o
// rises in the same cycle.
// ----------------------------------------------------------------------------
module receive_reorder_window_top #(
  parameter int unsigned SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rrw_pkg::pkt_in_t  in_beat_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rrw_pkg::result_t  out_beat_o
);

  localparam int unsigned AddrW = $clog2(SLOTS);

  logic                            accept_in, s1_adv, clearing;
  logic                            s1_v_q, s1_v_d, out_v_q, out_v_d;
  rrw_pkg::pkt_in_t                s1_q;
  rrw_pkg::result_t                out_q, res;
  logic signed [rrw_pkg::MaxW-1:0] max_q, max_d;
  logic                            store, we;
  logic [AddrW-1:0]                waddr, raddr_a, raddr_b;
  logic [rrw_pkg::SeqW-1:0]        rdata_a, rdata_b, cur_seq, next_seq, fwd_q;
  logic                            hit_a_q, hit_b_q;

  assign accept_in  = in_valid_i && !in_stall_o;
  assign s1_adv     = s1_v_q && (!out_v_q || !out_stall_i);
  assign in_stall_o = clearing || (s1_v_q && !s1_adv);

  assign raddr_a = in_beat_i.seq[AddrW-1:0];
  assign raddr_b = in_beat_i.delivered_seq[AddrW-1:0] + AddrW'(1);
  assign we      = s1_adv && store;
  assign waddr   = s1_q.seq[AddrW-1:0];

  rrw_slot_mem #(
    .SLOTS(SLOTS)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (we),
    .waddr_i    (waddr),
    .wdata_i    (s1_q.seq),
    .re_i       (accept_in),
    .raddr_a_i  (raddr_a),
    .raddr_b_i  (raddr_b),
    .rdata_a_o  (rdata_a),
    .rdata_b_o  (rdata_b),
    .clearing_o (clearing)
  );

  // The beat leaving the stage writes in the same edge as the new beat reads,
  // so its write is caught here and takes the place of the stale read.
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s1_q    <= in_beat_i;
      hit_a_q <= we && (waddr == raddr_a);
      hit_b_q <= we && (waddr == raddr_b);
      fwd_q   <= s1_q.seq;
    end
  end

  assign cur_seq  = hit_a_q ? fwd_q : rdata_a;
  assign next_seq = hit_b_q ? fwd_q : rdata_b;

  rrw_eval #(
    .SLOTS(SLOTS)
  ) u_eval (
    .pkt_i      (s1_q),
    .cur_seq_i  (cur_seq),
    .next_seq_i (next_seq),
    .max_i      (max_q),
    .max_o      (max_d),
    .store_o    (store),
    .res_o      (res)
  );

  assign s1_v_d  = accept_in || (s1_v_q && !s1_adv);
  assign out_v_d = s1_adv || (out_v_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      max_q   <= -32'sd1;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
      if (s1_adv) begin
        max_q <= max_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_beat_o  = out_q;

  a_no_status_without_store : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.store_payload || out_beat_o.status == rrw_pkg::StAccept)
  ) else $error("status other than accept on a beat that stores nothing");

  a_max_monotonic : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (max_q >= $past(max_q))
  ) else $error("highest stored sequence went down");

  a_no_write_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !we
  ) else $error("slot write during the clearing pass");

  a_accept_fills_stage : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> s1_v_q
  ) else $error("accepted beat lost before evaluation");

endmodule

FILE: design/rrw_slot_mem.sv
// ----------------------------------------------------------------------------
// Reorder window slot sequence memory
// One write port and two registered read ports, with a clearing pass that
// zeroes every entry after reset.
// ----------------------------------------------------------------------------
module rrw_slot_mem #(
  parameter int unsigned SLOTS = 64,
  localparam int unsigned AddrW = $clog2(SLOTS)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [rrw_pkg::SeqW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_a_i,
  input  logic [AddrW-1:0]         raddr_b_i,
  output logic [rrw_pkg::SeqW-1:0] rdata_a_o,
  output logic [rrw_pkg::SeqW-1:0] rdata_b_o,
  output logic                     clearing_o
);

  logic [rrw_pkg::SeqW-1:0] mem [SLOTS];
  logic [rrw_pkg::SeqW-1:0] rdata_a_q, rdata_b_q;
  logic                     clr_q, clr_d;
  logic [AddrW-1:0]         clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == AddrW'(SLOTS - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o  = rdata_a_q;
  assign rdata_b_o  = rdata_b_q;
  assign clearing_o = clr_q;

endmodule

FILE: design/rrw_eval.sv
// ----------------------------------------------------------------------------
// Reorder window packet evaluation
// Decides from the packet and the two slot reads whether to store, whether
// the window is full, and the new highest stored sequence.
// ----------------------------------------------------------------------------
module rrw_eval #(
  parameter int unsigned SLOTS = 64
) (
  input  rrw_pkg::pkt_in_t                  pkt_i,
  input  logic [rrw_pkg::SeqW-1:0]          cur_seq_i,
  input  logic [rrw_pkg::SeqW-1:0]          next_seq_i,
  input  logic signed [rrw_pkg::MaxW-1:0]   max_i,
  output logic signed [rrw_pkg::MaxW-1:0]   max_o,
  output logic                              store_o,
  output rrw_pkg::result_t                  res_o
);

  localparam logic [rrw_pkg::SlotOutW-1:0] SlotMask =
      rrw_pkg::SlotOutW'((SLOTS - 1) > 63 ? 63 : (SLOTS - 1));

  logic signed [32:0] seq_x, done_x;
  logic signed [33:0] ahead;
  logic [32:0]        next_x;
  logic               newer, present, full, next_ok, raise;

  always_comb begin
    seq_x   = {2'b00, pkt_i.seq};
    done_x  = {pkt_i.delivered_seq[31], pkt_i.delivered_seq};
    newer   = done_x < seq_x;
    // Sequence zero is never taken as present, since a cleared slot also reads zero.
    present = (cur_seq_i == pkt_i.seq) && (pkt_i.seq != '0);
    store_o = newer && !present;

    ahead   = {seq_x[32], seq_x} - {done_x[32], done_x};
    full    = ahead == 34'(SLOTS);
    next_x  = done_x + 33'sd1;
    next_ok = !next_x[32] && (next_x[31:0] == {1'b0, next_seq_i});

    raise   = store_o && ($signed({1'b0, pkt_i.seq}) > max_i);
    max_o   = raise ? $signed({1'b0, pkt_i.seq}) : max_i;

    res_o.status = rrw_pkg::StAccept;
    if (store_o && full) begin
      res_o.status = next_ok ? rrw_pkg::StDrain : rrw_pkg::StGap;
    end
    res_o.slot          = pkt_i.seq[rrw_pkg::SlotOutW-1:0] & SlotMask;
    res_o.store_payload = store_o;
    res_o.highest_seq   = max_o;
  end

endmodule
